/* rtl/dba_pkg.sv */
package dba_pkg;

  localparam int unsigned BLOCKS_DEFAULT = 64;

  localparam logic KIND_CONTIG = 1'b0;
  localparam logic KIND_CHAIN  = 1'b1;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_OVERLAP  = 2'd1;
  localparam logic [1:0] STATUS_PAST_END = 2'd2;
  localparam logic [1:0] STATUS_SHORT    = 2'd3;

  typedef struct packed {
    logic       kind;
    logic [5:0] start_block;
    logic [6:0] length;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [5:0] block;
    logic       last;
  } result_t;

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_CSCAN  = 6'b000100,
    S_CMARK  = 6'b001000,
    S_CHSCAN = 6'b010000,
    S_FLUSH  = 6'b100000
  } state_e;

endpackage

/* rtl/disk_block_allocator.sv */
// Disk block allocator. Takes one request when start_i is high and busy_o is low. A contiguous
// request checks its range one block per cycle and, if no block in it is used, then marks it
// one block per cycle; a range past the end or a zero length finishes without a scan. A chained
// request scans the used map upward from block 0, one block per cycle, and stops when length
// blocks are taken or the map ends. The used map is read one entry per cycle through a
// registered read port. After reset the block sweeps the used map clear while busy_o is high.
// Each result is shown for exactly one cycle with result_valid_o high and cannot be held off;
// a chained request gives one result per allocated block, the final one marked by last, or a
// single result if no block is allocated.
module disk_block_allocator #(
  parameter int unsigned BLOCKS = dba_pkg::BLOCKS_DEFAULT
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  dba_pkg::req_t   req_i,
  output logic            busy_o,
  output logic            result_valid_o,
  output dba_pkg::result_t result_o
);

  localparam int unsigned IW = $clog2(BLOCKS);
  localparam int unsigned SW = ((IW > 7) ? IW : 7) + 1;

  dba_pkg::state_e state_q, state_d;
  logic [IW-1:0]   addr_q, addr_d;
  logic [IW-1:0]   end_q, end_d;
  logic [IW-1:0]   first_q, first_d;
  logic            done_q, done_d;
  logic            chk_v_q, chk_v_d;
  logic [IW-1:0]   chk_addr_q, chk_addr_d;
  logic [6:0]      len_q, len_d;
  logic [6:0]      taken_q, taken_d;
  logic            pend_v_q, pend_v_d;
  logic [IW-1:0]   pend_q, pend_d;
  logic            chain_v_q, chain_v_d;
  logic [IW-1:0]   last_q, last_d;
  dba_pkg::result_t fin_q, fin_d;
  logic            out_v_q, out_v_d;
  dba_pkg::result_t out_q, out_d;

  logic          used_we;
  logic [IW-1:0] used_waddr;
  logic          used_wdata;
  logic          used_rdata;
  logic          link_we;

  logic [SW-1:0] range_end;
  logic          accept;

  assign accept    = start_i && (state_q == dba_pkg::S_IDLE);
  assign range_end = SW'(req_i.start_block) + SW'(req_i.length);

  dba_ram #(
    .WIDTH (1),
    .DEPTH (BLOCKS)
  ) u_used_ram (
    .clk_i   (clk_i),
    .we_i    (used_we),
    .waddr_i (used_waddr),
    .wdata_i (used_wdata),
    .raddr_i (addr_q),
    .rdata_o (used_rdata)
  );

  dba_ram #(
    .WIDTH (IW),
    .DEPTH (BLOCKS)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (last_q),
    .wdata_i (chk_addr_q),
    .raddr_i ('0),
    .rdata_o ()
  );

  always_comb begin
    state_d    = state_q;
    addr_d     = addr_q;
    end_d      = end_q;
    first_d    = first_q;
    done_d     = done_q;
    chk_v_d    = 1'b0;
    chk_addr_d = chk_addr_q;
    len_d      = len_q;
    taken_d    = taken_q;
    pend_v_d   = pend_v_q;
    pend_d     = pend_q;
    chain_v_d  = chain_v_q;
    last_d     = last_q;
    fin_d      = fin_q;
    out_v_d    = 1'b0;
    out_d      = out_q;
    used_we    = 1'b0;
    used_waddr = addr_q;
    used_wdata = 1'b0;
    link_we    = 1'b0;

    // pipelined read issue shared by both scans
    if ((state_q == dba_pkg::S_CSCAN || state_q == dba_pkg::S_CHSCAN) && !done_q) begin
      chk_v_d    = 1'b1;
      chk_addr_d = addr_q;
      if (addr_q == end_q) begin
        done_d = 1'b1;
      end else begin
        addr_d = addr_q + 1'b1;
      end
    end

    unique case (state_q)
      dba_pkg::S_CLEAR: begin
        used_we    = 1'b1;
        used_waddr = addr_q;
        used_wdata = 1'b0;
        if (addr_q == IW'(BLOCKS - 1)) begin
          state_d = dba_pkg::S_IDLE;
        end else begin
          addr_d = addr_q + 1'b1;
        end
      end
      dba_pkg::S_IDLE: begin
        if (accept) begin
          len_d    = req_i.length;
          taken_d  = '0;
          pend_v_d = 1'b0;
          done_d   = 1'b0;
          if (req_i.kind == dba_pkg::KIND_CONTIG) begin
            fin_d.block = req_i.start_block;
            fin_d.last  = 1'b1;
            if (range_end > SW'(BLOCKS)) begin
              fin_d.status = dba_pkg::STATUS_PAST_END;
              state_d      = dba_pkg::S_FLUSH;
            end else if (req_i.length == '0) begin
              fin_d.status = dba_pkg::STATUS_OK;
              state_d      = dba_pkg::S_FLUSH;
            end else begin
              addr_d  = IW'(req_i.start_block);
              first_d = IW'(req_i.start_block);
              end_d   = IW'(range_end - SW'(1));
              state_d = dba_pkg::S_CSCAN;
            end
          end else begin
            fin_d.block  = '0;
            fin_d.last   = 1'b1;
            fin_d.status = dba_pkg::STATUS_OK;
            if (req_i.length == '0) begin
              state_d = dba_pkg::S_FLUSH;
            end else begin
              addr_d  = '0;
              end_d   = IW'(BLOCKS - 1);
              state_d = dba_pkg::S_CHSCAN;
            end
          end
        end
      end
      dba_pkg::S_CSCAN: begin
        if (chk_v_q) begin
          if (used_rdata) begin
            fin_d.status = dba_pkg::STATUS_OVERLAP;
            state_d      = dba_pkg::S_FLUSH;
          end else if (chk_addr_q == end_q) begin
            addr_d  = first_q;
            state_d = dba_pkg::S_CMARK;
          end
        end
      end
      dba_pkg::S_CMARK: begin
        used_we    = 1'b1;
        used_waddr = addr_q;
        used_wdata = 1'b1;
        if (addr_q == end_q) begin
          fin_d.status = dba_pkg::STATUS_OK;
          state_d      = dba_pkg::S_FLUSH;
        end else begin
          addr_d = addr_q + 1'b1;
        end
      end
      dba_pkg::S_CHSCAN: begin
        if (chk_v_q) begin
          if (!used_rdata) begin
            used_we    = 1'b1;
            used_waddr = chk_addr_q;
            used_wdata = 1'b1;
            link_we    = chain_v_q;
            chain_v_d  = 1'b1;
            last_d     = chk_addr_q;
            taken_d    = taken_q + 1'b1;
            pend_v_d   = 1'b1;
            pend_d     = chk_addr_q;
            if (pend_v_q) begin
              out_v_d = 1'b1;
              out_d   = '{status: dba_pkg::STATUS_OK, block: 6'(pend_q), last: 1'b0};
            end
            if (taken_q + 1'b1 == len_q) begin
              fin_d.block  = 6'(chk_addr_q);
              fin_d.status = dba_pkg::STATUS_OK;
              state_d      = dba_pkg::S_FLUSH;
            end else if (chk_addr_q == end_q) begin
              fin_d.block  = 6'(chk_addr_q);
              fin_d.status = dba_pkg::STATUS_SHORT;
              state_d      = dba_pkg::S_FLUSH;
            end
          end else if (chk_addr_q == end_q) begin
            fin_d.block  = pend_v_q ? 6'(pend_q) : 6'd0;
            fin_d.status = dba_pkg::STATUS_SHORT;
            state_d      = dba_pkg::S_FLUSH;
          end
        end
      end
      dba_pkg::S_FLUSH: begin
        out_v_d = 1'b1;
        out_d   = fin_q;
        state_d = dba_pkg::S_IDLE;
      end
      default: begin
        state_d = dba_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= dba_pkg::S_CLEAR;
      addr_q    <= '0;
      done_q    <= 1'b0;
      chk_v_q   <= 1'b0;
      pend_v_q  <= 1'b0;
      chain_v_q <= 1'b0;
      taken_q   <= '0;
      out_v_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      addr_q    <= addr_d;
      done_q    <= done_d;
      chk_v_q   <= chk_v_d;
      pend_v_q  <= pend_v_d;
      chain_v_q <= chain_v_d;
      taken_q   <= taken_d;
      out_v_q   <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    end_q      <= end_d;
    first_q    <= first_d;
    chk_addr_q <= chk_addr_d;
    len_q      <= len_d;
    pend_q     <= pend_d;
    last_q     <= last_d;
    fin_q      <= fin_d;
    out_q      <= out_d;
  end

  assign busy_o         = (state_q != dba_pkg::S_IDLE);
  assign result_valid_o = out_v_q;
  assign result_o       = out_q;

endmodule

/* rtl/dba_ram.sv */
module dba_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/dba_checker.sv */
module dba_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start_i,
  input logic             busy_o,
  input logic             result_valid_o,
  input dba_pkg::result_t result_o
);

  // an accepted request makes the block busy in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("request accepted but block not busy");

  // the final result coincides with the block becoming free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.last) |-> !busy_o)
    else $error("busy after final result");

  // the block stays busy while a non-final result is shown, as more results follow
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !result_o.last) |-> busy_o)
    else $error("idle after non-final result");

  // only the final result can carry an error status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !result_o.last) |-> (result_o.status == dba_pkg::STATUS_OK))
    else $error("error status on non-final result");

endmodule

bind disk_block_allocator dba_checker u_dba_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .result_valid_o (result_valid_o),
  .result_o       (result_o)
);
